[rtl/branch_target_hashed_predictor_core_defines.svh]
// Assertion macros shared by the branch target hashed predictor RTL.
`ifndef BRANCH_TARGET_HASHED_PREDICTOR_CORE_DEFINES_SVH
`define BRANCH_TARGET_HASHED_PREDICTOR_CORE_DEFINES_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define BTHP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Checks that the consequent holds in the cycle after the antecedent.
`define BTHP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

[rtl/bthp_pkg.sv]
// Shared types and constants for the branch target hashed predictor.
`default_nettype none

package bthp_pkg;

    localparam int INDEX_BITS_EACH_DEF = 5;
    localparam int COUNT_WIDTH_DEF     = 32;
    localparam int ADDR_WIDTH          = 64;
    localparam int TOTAL_WIDTH         = 32;
    localparam int S_TDATA_WIDTH       = 136;
    localparam int M_TDATA_WIDTH       = 104;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    typedef struct packed {
        logic clear_en;
        logic load;
        logic exec;
    } ctrl_cmd_t;

    typedef struct packed {
        logic clear_last;
        logic out_free;
    } dp_status_t;

endpackage

`default_nettype wire

[rtl/bthp_ctrl.sv]
// Controller state machine: clearing pass, word intake and update sequencing.
`default_nettype none

module bthp_ctrl (
    input  wire                  clk,
    input  wire                  rst_n,
    input  wire                  s_tvalid,
    output logic                 s_tready,
    input  bthp_pkg::dp_status_t status,
    output bthp_pkg::ctrl_cmd_t  cmd
);

    bthp_pkg::state_t state_reg;
    bthp_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= bthp_pkg::S_CLEAR;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        s_tready     = 1'b0;
        cmd.clear_en = 1'b0;
        cmd.load     = 1'b0;
        cmd.exec     = 1'b0;
        case (state_reg)
            bthp_pkg::S_CLEAR:
            begin
                cmd.clear_en = 1'b1;
                if (status.clear_last)
                begin
                    state_next = bthp_pkg::S_IDLE;
                end
            end
            bthp_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = bthp_pkg::S_EXEC;
                end
            end
            bthp_pkg::S_EXEC:
            begin
                if (status.out_free)
                begin
                    cmd.exec   = 1'b1;
                    state_next = bthp_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = bthp_pkg::S_CLEAR;
            end
        endcase
    end

endmodule

`default_nettype wire

[rtl/bthp_dp.sv]
// Datapath: direction and tag memories, counters and the result register.
`default_nettype none

module bthp_dp #(
    parameter int INDEX_BITS_EACH = bthp_pkg::INDEX_BITS_EACH_DEF,
    parameter int COUNT_WIDTH     = bthp_pkg::COUNT_WIDTH_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  bthp_pkg::ctrl_cmd_t                 cmd,
    output bthp_pkg::dp_status_t                status,
    input  wire [bthp_pkg::S_TDATA_WIDTH-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [bthp_pkg::M_TDATA_WIDTH-1:0]  m_tdata
);

    localparam int IDX_W = 2 * INDEX_BITS_EACH;
    localparam int DEPTH = 1 << IDX_W;
    localparam int AW    = bthp_pkg::ADDR_WIDTH;

    logic [AW-1:0] tag_mem [DEPTH];
    logic          dir_mem [DEPTH];

    logic [IDX_W-1:0]       clr_addr_reg;
    logic [IDX_W-1:0]       idx_reg;
    logic [AW-1:0]          branch_reg;
    logic                   taken_reg;
    logic [AW-1:0]          tag_rd_reg;
    logic                   dir_rd_reg;
    logic [COUNT_WIDTH-1:0] correct_cnt_reg;
    logic [COUNT_WIDTH-1:0] incorrect_cnt_reg;
    logic [COUNT_WIDTH-1:0] collision_cnt_reg;
    logic [COUNT_WIDTH-1:0] correct_cnt_next;
    logic [COUNT_WIDTH-1:0] incorrect_cnt_next;
    logic [COUNT_WIDTH-1:0] collision_cnt_next;
    logic                   out_valid_reg;
    logic [bthp_pkg::M_TDATA_WIDTH-1:0] out_data_reg;
    logic [bthp_pkg::M_TDATA_WIDTH-1:0] out_data_next;

    logic [AW-1:0]    in_branch;
    logic [AW-1:0]    in_target;
    logic [IDX_W-1:0] in_idx;
    logic             hit_other;
    logic             right;
    logic             mem_we;
    logic [IDX_W-1:0] mem_waddr;

    assign in_branch = s_tdata[AW-1:0];
    assign in_target = s_tdata[2*AW-1:AW];
    assign in_idx    = {in_branch[INDEX_BITS_EACH-1:0], in_target[INDEX_BITS_EACH-1:0]};

    assign hit_other = (tag_rd_reg != branch_reg);
    assign right     = (dir_rd_reg == taken_reg);

    assign mem_we    = cmd.clear_en || cmd.exec;
    assign mem_waddr = cmd.clear_en ? clr_addr_reg : idx_reg;

    always_ff @(posedge clk)
    begin
        if (mem_we && (cmd.clear_en || hit_other))
        begin
            tag_mem[mem_waddr] <= cmd.clear_en ? '0 : branch_reg;
        end
        if (mem_we && (cmd.clear_en || !right))
        begin
            dir_mem[mem_waddr] <= cmd.clear_en ? 1'b0 : taken_reg;
        end
        if (cmd.load)
        begin
            tag_rd_reg <= tag_mem[in_idx];
            dir_rd_reg <= dir_mem[in_idx];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            idx_reg    <= in_idx;
            branch_reg <= in_branch;
            taken_reg  <= s_tdata[2*AW];
        end
        if (cmd.exec)
        begin
            out_data_reg <= out_data_next;
        end
    end

    always_comb
    begin
        correct_cnt_next   = correct_cnt_reg;
        incorrect_cnt_next = incorrect_cnt_reg;
        collision_cnt_next = collision_cnt_reg;
        if (hit_other)
        begin
            if (collision_cnt_reg != '1)
            begin
                collision_cnt_next = collision_cnt_reg + 1'b1;
            end
        end
        else if (right)
        begin
            if (correct_cnt_reg != '1)
            begin
                correct_cnt_next = correct_cnt_reg + 1'b1;
            end
        end
        else
        begin
            if (incorrect_cnt_reg != '1)
            begin
                incorrect_cnt_next = incorrect_cnt_reg + 1'b1;
            end
        end
        out_data_next = {5'b0,
                         bthp_pkg::TOTAL_WIDTH'(collision_cnt_next),
                         bthp_pkg::TOTAL_WIDTH'(incorrect_cnt_next),
                         bthp_pkg::TOTAL_WIDTH'(correct_cnt_next),
                         hit_other, right, dir_rd_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_addr_reg      <= '0;
            correct_cnt_reg   <= '0;
            incorrect_cnt_reg <= '0;
            collision_cnt_reg <= '0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            if (cmd.clear_en)
            begin
                clr_addr_reg <= clr_addr_reg + 1'b1;
            end
            if (cmd.exec)
            begin
                correct_cnt_reg   <= correct_cnt_next;
                incorrect_cnt_reg <= incorrect_cnt_next;
                collision_cnt_reg <= collision_cnt_next;
                out_valid_reg     <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign status.clear_last = (clr_addr_reg == '1);
    assign status.out_free   = !out_valid_reg || m_tready;
    assign m_tvalid          = out_valid_reg;
    assign m_tdata           = out_data_reg;

endmodule

`default_nettype wire

[rtl/branch_target_hashed_predictor_core.sv]
// Top level of the branch target hashed one-bit direction predictor.
`default_nettype none

`include "branch_target_hashed_predictor_core_defines.svh"

// Each input word is one resolved branch; each output word reports the prediction made
// from the one-bit direction table, whether the tag store held a different branch, and
// the saturating totals. The table and tag memories are read on the accepting edge and
// written back with the counters when the result enters the output register, which waits
// while the previous result is still held there; s_tready returns only after that write,
// so one word is in flight at a time. After reset both memories are cleared one entry
// per cycle, all 2^(2*INDEX_BITS_EACH) entries (1024 by default), with s_tready held low.
module branch_target_hashed_predictor_core #(
    parameter int INDEX_BITS_EACH = bthp_pkg::INDEX_BITS_EACH_DEF,
    parameter int COUNT_WIDTH     = bthp_pkg::COUNT_WIDTH_DEF
) (
    input  wire                                 clk,
    input  wire                                 rst_n,
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    // branch_addr[63:0], target_addr[127:64], taken[128], zero fill above.
    input  wire [bthp_pkg::S_TDATA_WIDTH-1:0]   s_tdata,
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    // predicted_taken[0], prediction_correct[1], collision[2], correct_total[34:3],
    // incorrect_total[66:35], collision_total[98:67], zero fill above.
    output logic [bthp_pkg::M_TDATA_WIDTH-1:0]  m_tdata
);

    bthp_pkg::ctrl_cmd_t  cmd;
    bthp_pkg::dp_status_t status;

    bthp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    bthp_dp #(
        .INDEX_BITS_EACH (INDEX_BITS_EACH),
        .COUNT_WIDTH     (COUNT_WIDTH)
    ) u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .status   (status),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    `BTHP_ASSERT_NOW(a_clear_excl, cmd.clear_en, !cmd.load && !cmd.exec && !m_tvalid)
    `BTHP_ASSERT_NEXT(a_one_in_flight, s_tvalid && s_tready, !s_tready)
    `BTHP_ASSERT_NEXT(a_exec_shows, cmd.exec, m_tvalid && s_tready)

endmodule

`default_nettype wire

[dv/tb_branch_target_hashed_predictor_core.sv]
`timescale 1ns / 1ps
// Self-checking testbench for the branch target hashed one-bit direction predictor.
module tb_branch_target_hashed_predictor_core;

    localparam int INDEX_BITS_EACH_DEF = bthp_pkg::INDEX_BITS_EACH_DEF;
    localparam int COUNT_WIDTH_DEF     = bthp_pkg::COUNT_WIDTH_DEF;
    localparam int ADDR_WIDTH          = bthp_pkg::ADDR_WIDTH;
    localparam int TOTAL_WIDTH         = bthp_pkg::TOTAL_WIDTH;
    localparam int S_TDATA_WIDTH       = bthp_pkg::S_TDATA_WIDTH;
    localparam int M_TDATA_WIDTH       = bthp_pkg::M_TDATA_WIDTH;

    localparam int IDX_W       = 2 * INDEX_BITS_EACH_DEF;
    localparam int TABLE_DEPTH = 1 << IDX_W;
    localparam int POOL_SIZE   = 24;
    localparam int MAX_REPORTS = 10;
    localparam int FILL_W      = S_TDATA_WIDTH - (2 * ADDR_WIDTH + 1);

    typedef struct packed {
        logic [TOTAL_WIDTH-1:0] collision_total;
        logic [TOTAL_WIDTH-1:0] incorrect_total;
        logic [TOTAL_WIDTH-1:0] correct_total;
        logic                   collision;
        logic                   prediction_correct;
        logic                   predicted_taken;
    } verdict_t;

    typedef enum int {
        READY_ALWAYS,
        READY_RANDOM,
        READY_BURSTY,
        READY_PERIODIC
    } ready_mode_t;

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    // branch_addr[63:0], target_addr[127:64], taken[128], zero fill above.
    logic [S_TDATA_WIDTH-1:0] s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    // predicted_taken[0], prediction_correct[1], collision[2], correct_total[34:3],
    // incorrect_total[66:35], collision_total[98:67], zero fill above.
    logic [M_TDATA_WIDTH-1:0] m_tdata;

    // Shadow copy of the predictor state.
    logic                       dir_bit [TABLE_DEPTH];
    logic [ADDR_WIDTH-1:0]      owner_tag [TABLE_DEPTH];
    logic [COUNT_WIDTH_DEF-1:0] correct_cnt;
    logic [COUNT_WIDTH_DEF-1:0] incorrect_cnt;
    logic [COUNT_WIDTH_DEF-1:0] collision_cnt;

    verdict_t expected_verdicts[$];

    logic [ADDR_WIDTH-1:0] pool_branch [POOL_SIZE];
    logic [ADDR_WIDTH-1:0] pool_target [POOL_SIZE];
    logic                  pool_bias [POOL_SIZE];

    int  fail_count;
    int  checked_words;
    int  sent_words;
    int  seen_collisions;
    int  seen_mispredicts;
    int  burst_left;
    bit  steady_stream;

    branch_target_hashed_predictor_core i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #2ms;
        $display("simulation failed");
        $finish;
    end

    function automatic logic [COUNT_WIDTH_DEF-1:0] bump(input logic [COUNT_WIDTH_DEF-1:0] c);
        return (&c) ? c : c + 1'b1;
    endfunction

    task automatic resolve_branch(input logic [ADDR_WIDTH-1:0] br, input logic [ADDR_WIDTH-1:0] tg,
                                  input logic tk);
        logic [IDX_W-1:0] idx;
        verdict_t         v;
        idx = {br[INDEX_BITS_EACH_DEF-1:0], tg[INDEX_BITS_EACH_DEF-1:0]};
        v = '0;
        v.collision = (owner_tag[idx] != br);
        if (v.collision)
        begin
            owner_tag[idx] = br;
            collision_cnt = bump(collision_cnt);
            seen_collisions++;
        end
        v.predicted_taken = dir_bit[idx];
        v.prediction_correct = (dir_bit[idx] == tk);
        if (!v.prediction_correct)
        begin
            dir_bit[idx] = tk;
            seen_mispredicts++;
        end
        if (!v.collision)
        begin
            if (v.prediction_correct)
                correct_cnt = bump(correct_cnt);
            else
                incorrect_cnt = bump(incorrect_cnt);
        end
        v.correct_total = correct_cnt[TOTAL_WIDTH-1:0];
        v.incorrect_total = incorrect_cnt[TOTAL_WIDTH-1:0];
        v.collision_total = collision_cnt[TOTAL_WIDTH-1:0];
        expected_verdicts.push_back(v);
    endtask

    task automatic send_branch(input logic [ADDR_WIDTH-1:0] br, input logic [ADDR_WIDTH-1:0] tg,
                               input logic tk);
        int gap;
        if (burst_left == 0)
        begin
            gap = steady_stream ? 0 : $urandom_range(0, 6);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 16);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata <= {{FILL_W{1'b0}}, tk, tg, br};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        resolve_branch(br, tg, tk);
        sent_words++;
    endtask

    function automatic logic [ADDR_WIDTH-1:0] rand_addr();
        return {$urandom, $urandom};
    endfunction

    task automatic refill_pool_entry(input int k);
        pool_branch[k] = rand_addr();
        pool_branch[k][INDEX_BITS_EACH_DEF-1:0] = INDEX_BITS_EACH_DEF'($urandom_range(0, 7));
        pool_target[k] = rand_addr();
        pool_target[k][INDEX_BITS_EACH_DEF-1:0] = INDEX_BITS_EACH_DEF'($urandom_range(0, 3));
        pool_bias[k] = 1'($urandom_range(0, 1));
    endtask

    // A recurring branch from the pool, mostly following its own direction.
    task automatic send_trace_branch();
        int   k;
        logic tk;
        k = $urandom_range(0, POOL_SIZE - 1);
        tk = ($urandom_range(0, 99) < 85) ? pool_bias[k] : ~pool_bias[k];
        send_branch(pool_branch[k], pool_target[k], tk);
    endtask

    task automatic test_first_visit();
        send_branch('0, '0, 1'b0);
        send_branch('0, '0, 1'b1);
        send_branch('0, '0, 1'b1);
        send_branch('0, '0, 1'b0);
    endtask

    task automatic test_collisions();
        send_branch('1, '1, 1'b1);
        send_branch('1, '1, 1'b1);
        send_branch(64'h20, '0, 1'b1);
        send_branch('0, '0, 1'b1);
        send_branch('0, '0, 1'b1);
        send_branch(64'h40, 64'h20, 1'b0);
        send_branch(64'h7c0, 64'h20, 1'b0);
    endtask

    task automatic test_field_extremes();
        send_branch(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b1);
        send_branch(64'h5555_5555_5555_5555, 64'haaaa_aaaa_aaaa_aaaa, 1'b0);
        send_branch(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001, 1'b1);
        send_branch(64'h0000_0000_0000_0001, 64'h8000_0000_0000_0000, 1'b1);
        send_branch(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001, 1'b0);
        send_branch(64'hffff_ffff_ffff_ffe0, 64'h0000_0000_0000_001f, 1'b1);
        send_branch(64'h0000_0000_0000_001f, 64'hffff_ffff_ffff_ffe0, 1'b0);
        send_branch(64'haaaa_aaaa_aaaa_aaaa, 64'h5555_5555_5555_5555, 1'b1);
    endtask

    task automatic test_steady_stream();
        steady_stream = 1'b1;
        for (int k = 0; k < POOL_SIZE; k++)
            refill_pool_entry(k);
        repeat (80)
            send_trace_branch();
        steady_stream = 1'b0;
    endtask

    task automatic test_random_trace();
        int pick;
        int k;
        repeat (1050)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 10)
                send_branch(rand_addr(), rand_addr(), 1'($urandom_range(0, 1)));
            else if (pick < 14)
            begin
                k = $urandom_range(0, POOL_SIZE - 1);
                send_branch(pool_branch[k], rand_addr(), 1'($urandom_range(0, 1)));
            end
            else
                send_trace_branch();
            if ($urandom_range(0, 99) == 0)
                refill_pool_entry($urandom_range(0, POOL_SIZE - 1));
        end
    endtask

    initial
    begin : receiver
        ready_mode_t mode;
        int          span;
        int          hold;
        int          tick;
        logic        level;
        m_tready = 1'b0;
        hold = 0;
        tick = 0;
        level = 1'b1;
        forever
        begin
            mode = ready_mode_t'($urandom_range(0, 3));
            span = $urandom_range(50, 300);
            repeat (span)
            begin
                @(posedge clk);
                tick++;
                case (mode)
                    READY_ALWAYS:   m_tready <= 1'b1;
                    READY_RANDOM:   m_tready <= 1'($urandom_range(0, 1));
                    READY_PERIODIC: m_tready <= (tick % 3 == 0);
                    READY_BURSTY:
                    begin
                        if (hold == 0)
                        begin
                            level = ~level;
                            hold = $urandom_range(1, 12);
                        end
                        hold--;
                        m_tready <= level;
                    end
                    default:        m_tready <= 1'b1;
                endcase
            end
        end
    end

    always @(posedge clk)
    begin : result_check
        verdict_t got;
        verdict_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = verdict_t'(m_tdata[$bits(verdict_t)-1:0]);
            if (expected_verdicts.size() == 0)
            begin
                fail_count++;
                if (fail_count <= MAX_REPORTS)
                    $display("%0t: result word with none expected: %h", $realtime, got);
            end
            else
            begin
                want = expected_verdicts.pop_front();
                checked_words++;
                if (got.predicted_taken !== want.predicted_taken
                    || got.prediction_correct !== want.prediction_correct
                    || got.collision !== want.collision
                    || got.correct_total !== want.correct_total
                    || got.incorrect_total !== want.incorrect_total
                    || got.collision_total !== want.collision_total)
                begin
                    fail_count++;
                    if (fail_count <= MAX_REPORTS)
                    begin
                        $display("%0t: mismatch on word %0d", $realtime, checked_words);
                        $display("  expected taken=%b correct=%b coll=%b totals=%0d/%0d/%0d",
                                 want.predicted_taken, want.prediction_correct, want.collision,
                                 want.correct_total, want.incorrect_total, want.collision_total);
                        $display("  actual   taken=%b correct=%b coll=%b totals=%0d/%0d/%0d",
                                 got.predicted_taken, got.prediction_correct, got.collision,
                                 got.correct_total, got.incorrect_total, got.collision_total);
                    end
                end
            end
        end
    end

    initial
    begin
        for (int i = 0; i < TABLE_DEPTH; i++)
        begin
            dir_bit[i] = 1'b0;
            owner_tag[i] = '0;
        end
        correct_cnt = '0;
        incorrect_cnt = '0;
        collision_cnt = '0;
        fail_count = 0;
        checked_words = 0;
        sent_words = 0;
        seen_collisions = 0;
        seen_mispredicts = 0;
        burst_left = 0;
        steady_stream = 1'b0;
        rst_n = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        test_first_visit();
        test_collisions();
        test_field_extremes();
        test_steady_stream();
        test_random_trace();
        s_tvalid <= 1'b0;

        while (expected_verdicts.size() != 0)
            @(posedge clk);
        repeat (10) @(posedge clk);

        $display("Sent %0d branches and checked %0d result words.", sent_words, checked_words);
        $display("The trace held %0d tag collisions and %0d mispredicts.",
                 seen_collisions, seen_mispredicts);
        if (fail_count == 0 && expected_verdicts.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
